[rtl/u2ra_pkg.sv]
package u2ra_pkg;

	localparam int VALUE_WIDTH = 32;

	// decimal digits of 2^W-1, via log10(2) ~ 0.30103
	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

	// double-dabble consumes this many value bits per cycle
	localparam int STEP_BITS  = 8;
	localparam int NUM_STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int STEP_W     = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
	localparam int PAD_WIDTH  = NUM_STEPS * STEP_BITS;

	localparam logic [1:0] FUNC_DEC    = 2'd0;
	localparam logic [1:0] FUNC_HEX_LO = 2'd1;
	localparam logic [1:0] FUNC_HEX_UP = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_UP_A  = 7'h41;
	localparam logic [6:0] CHAR_LO_A  = 7'h61;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [1:0]             func;
	} in_item_t;

	typedef struct packed {
		logic [6:0] digit_char;
		logic       last_digit;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic load_dec;
		logic conv;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_last;
		logic idx_zero;
		logic out_free;
	} status_t;

	function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic upper);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'd0, d};
		end else if (upper) begin
			c = CHAR_UP_A + {3'd0, d - 4'd10};
		end else begin
			c = CHAR_LO_A + {3'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

[rtl/u2ra_ctrl.sv]
module u2ra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_func,
	input  u2ra_pkg::status_t  status,
	output logic               in_ready,
	output u2ra_pkg::cmd_t     cmd
);

	u2ra_pkg::state_t state_q;
	u2ra_pkg::state_t state_d;
	logic             take;

	assign take = in_valid && (state_q == u2ra_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2ra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			u2ra_pkg::ST_IDLE: begin
				// unlisted selector: transfer taken, nothing emitted
				if (in_valid && in_func != u2ra_pkg::FUNC_NONE) begin
					state_d = (in_func == u2ra_pkg::FUNC_DEC) ? u2ra_pkg::ST_CONV
						: u2ra_pkg::ST_SCAN;
				end
			end
			u2ra_pkg::ST_CONV: begin
				if (status.conv_last) begin
					state_d = u2ra_pkg::ST_SCAN;
				end
			end
			u2ra_pkg::ST_SCAN: begin
				state_d = u2ra_pkg::ST_EMIT;
			end
			u2ra_pkg::ST_EMIT: begin
				if (status.out_free && status.idx_zero) begin
					state_d = u2ra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = u2ra_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			u2ra_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load     = take && (in_func != u2ra_pkg::FUNC_NONE);
				cmd.load_dec = in_func == u2ra_pkg::FUNC_DEC;
			end
			u2ra_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
			end
			u2ra_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			u2ra_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/u2ra_dp.sv]
module u2ra_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  u2ra_pkg::in_item_t  in_data,
	input  u2ra_pkg::cmd_t      cmd,
	input  logic                out_ready,
	output logic                out_valid,
	output u2ra_pkg::out_item_t out_data,
	output u2ra_pkg::status_t   status
);

	localparam int DW = u2ra_pkg::NUM_DIGITS * 4;

	logic [u2ra_pkg::PAD_WIDTH-1:0]                value_q;
	logic [u2ra_pkg::NUM_DIGITS-1:0][3:0]          digits_q;
	logic [u2ra_pkg::STEP_W-1:0]                   step_q;
	logic [u2ra_pkg::DIG_IDX_W-1:0]                idx_q;
	logic                                          upper_q;
	logic                                          out_valid_q;
	u2ra_pkg::out_item_t                           out_data_q;

	logic [DW-1:0]                                 hex_ext;
	logic [DW-1:0]                                 bcd_next;
	logic [u2ra_pkg::PAD_WIDTH-1:0]                value_next;
	logic [u2ra_pkg::DIG_IDX_W-1:0]                top_idx;

	assign hex_ext = DW'(in_data.value);

	// eight shift-and-add-3 steps of double dabble
	always_comb begin
		logic [DW-1:0]                  bcd;
		logic [u2ra_pkg::PAD_WIDTH-1:0] val;
		bcd = digits_q;
		val = value_q;
		for (int b = 0; b < u2ra_pkg::STEP_BITS; b++) begin
			for (int d = 0; d < u2ra_pkg::NUM_DIGITS; d++) begin
				if (bcd[d*4 +: 4] >= 4'd5) begin
					bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
				end
			end
			bcd = {bcd[DW-2:0], val[u2ra_pkg::PAD_WIDTH-1]};
			val = {val[u2ra_pkg::PAD_WIDTH-2:0], 1'b0};
		end
		bcd_next   = bcd;
		value_next = val;
	end

	// most significant nonzero digit, zero when all digits are zero
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < u2ra_pkg::NUM_DIGITS; d++) begin
			if (digits_q[d] != 4'd0) begin
				top_idx = u2ra_pkg::DIG_IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			upper_q <= in_data.func == u2ra_pkg::FUNC_HEX_UP;
			value_q <= u2ra_pkg::PAD_WIDTH'(in_data.value);
			step_q  <= '0;
			if (cmd.load_dec) begin
				digits_q <= '0;
			end else begin
				digits_q <= hex_ext;
			end
		end else if (cmd.conv) begin
			digits_q <= bcd_next;
			value_q  <= value_next;
			step_q   <= step_q + 1'b1;
		end
		if (cmd.scan) begin
			idx_q <= top_idx;
		end else if (cmd.emit) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.emit) begin
			out_data_q.digit_char <= u2ra_pkg::digit_to_char(digits_q[idx_q], upper_q);
			out_data_q.last_digit <= idx_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.conv_last = step_q == u2ra_pkg::STEP_W'(u2ra_pkg::NUM_STEPS - 1);
	assign status.idx_zero  = idx_q == '0;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/unsigned_to_radix_ascii.sv]
// Unsigned number to ASCII digits, decimal or hex, most significant first.
// Input channel (in_valid/in_ready/in_data) carries a value and a selector:
// decimal, lower-case hex or upper-case hex. Selector code 3 is taken and
// dropped with no output. Output channel (out_valid/out_ready/out_data)
// carries one ASCII digit per transfer, last_digit set on the final one;
// leading zeros are suppressed and zero gives a single '0'.
// One value at a time: in_ready is high only while the controller is idle.
// Decimal: double dabble at eight bits per cycle, a scan state for the
// leading digit, then one digit per cycle into the output register
// while the receiver accepts. Hex skips the conversion.
// The output register lets the last digit wait while the next value is
// taken. A stalled receiver holds digit generation; nothing is dropped.
// Reset clears the controller and output valid; no state spans values.
module unsigned_to_radix_ascii (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  u2ra_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output u2ra_pkg::out_item_t out_data
);

	u2ra_pkg::cmd_t    cmd;
	u2ra_pkg::status_t status;

	u2ra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	u2ra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (status)
	);

endmodule
